// File: hdl/ngahr_pkg.sv
// Package with shared constants and types of the noise gate.
`default_nettype none
package ngahr_pkg;

    // Default sizes handed to the top level.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;

    // Register and field widths.
    localparam int LEN_W      = 24;
    localparam int THR_W      = 16;
    localparam int K_W        = 17;
    localparam int GAIN_W     = 17;
    localparam int QUO_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_CNT_W  = 4;

    localparam logic [GAIN_W-1:0] UNITY = 17'd65536;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0] ATTACK_RST    = 24'd480;
    localparam logic [LEN_W-1:0] HOLD_RST      = 24'd0;
    localparam logic [LEN_W-1:0] RELEASE_RST   = 24'd4800;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd0;
    localparam logic [K_W-1:0]   SMOOTHING_RST = 17'd58982;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_MK   = 2'd1,
        MUL_ENV  = 2'd2,
        MUL_OUT  = 2'd3
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     env_hold;
        logic     env_upd;
        logic     decide;
        logic     div_step;
        logic     gain_upd;
        logic     out_load;
    } ngahr_cmd_t;

endpackage
`default_nettype wire

// File: hdl/ngahr_in_if.sv
// Request channel carrying one input sample.
`default_nettype none
interface ngahr_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface
`default_nettype wire

// File: hdl/ngahr_out_if.sv
// Request channel carrying one gated sample and the gate flag.
`default_nettype none
interface ngahr_out_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          gate_open;

    modport source (output valid, output sample_out, output gate_open, input ready);
    modport sink (input valid, input sample_out, input gate_open, output ready);
endinterface
`default_nettype wire

// File: hdl/noise_gate_attack_hold_release.sv
// Top level of the noise gate with attack, hold and release.
//
// A sample enters on in_ch and its gated value, with the gate flag, leaves
// on out_ch; both are valid/ready channels and one request in gives exactly
// one request out. The configuration port writes a register when cfg_we is
// high: attack, hold and release lengths, threshold and smoothing.
// Each sample passes the shared multiplier three times and the ramp divider,
// which yields one quotient bit a cycle until all 16 bits of the quotient
// are formed. One sample is processed at a time: a new one is accepted only
// when the controller is back in idle.
// Results wait in an output register: the next sample is accepted while a
// result is still held there, and when the receiver stalls the finished
// sample waits in the controller until the register frees up.
// Reset restores the default configuration, unity gain, an empty envelope
// and a gate in neither phase.
`default_nettype none
module noise_gate_attack_hold_release
    import ngahr_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ngahr_in_if.sink                   in_ch,
    ngahr_out_if.source                out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ngahr_cmd_t cmd;

    // Sequencer.
    ngahr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .cmd       (cmd)
    );

    // Arithmetic and state.
    ngahr_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample_in  (in_ch.sample_in),
        .sample_out (out_ch.sample_out),
        .gate_open  (out_ch.gate_open),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data)
    );

endmodule
`default_nettype wire

// File: hdl/ngahr_ctrl.sv
// Controller state machine sequencing one sample through the datapath.
`default_nettype none
module ngahr_ctrl
    import ngahr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic out_ready,
    output logic      out_valid,
    output ngahr_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL_K  = 9'b000000010,
        S_MUL_E  = 9'b000000100,
        S_ENV    = 9'b000001000,
        S_DECIDE = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_GAIN   = 9'b001000000,
        S_MUL_O  = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_K;
                end
            end
            S_MUL_K:
            begin
                cmd.mul_sel = MUL_MK;
                state_next  = S_MUL_E;
            end
            S_MUL_E:
            begin
                cmd.mul_sel  = MUL_ENV;
                cmd.env_hold = 1'b1;
                state_next   = S_ENV;
            end
            S_ENV:
            begin
                cmd.env_upd = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide   = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == {DIV_CNT_W{1'b1}})
                begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                cmd.gain_upd = 1'b1;
                state_next   = S_MUL_O;
            end
            S_MUL_O:
            begin
                cmd.mul_sel = MUL_OUT;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/ngahr_dp.sv
// Datapath: configuration, gate state, shared multiplier and serial divider.
`default_nettype none
module ngahr_dp
    import ngahr_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ngahr_cmd_t                    cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    output logic                               gate_open,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int ENV_W  = SAMPLE_BITS + 17;
    localparam int PROD_W = K_W + ENV_W;
    localparam int CW     = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

    // Configuration registers.
    logic [LEN_W-1:0] attack_reg, hold_reg, release_reg;
    logic [THR_W-1:0] thr_reg;
    logic [K_W-1:0]   smooth_reg;

    // Per-sample working registers.
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic                   neg_reg;
    logic [K_W-1:0]         k_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [ENV_W-1:0]       acc_reg;
    logic                   open_reg;
    logic                   hold_ok_reg;
    logic                   cap_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       rem_reg;
    logic [QUO_W-1:0]       quo_reg;

    // Gate state.
    logic [GAIN_W-1:0]     gain_reg, low_reg, peak_reg;
    logic [ENV_W-1:0]      env_reg;
    logic [COUNT_BITS-1:0] cnt_reg, ostart_reg, cstart_reg;
    logic                  ph_open_reg, ph_close_reg;

    // Output register.
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_gate_reg;

    assign sample_out = signed'(out_sample_reg);
    assign gate_open  = out_gate_reg;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= ATTACK_RST;
            hold_reg    <= HOLD_RST;
            release_reg <= RELEASE_RST;
            thr_reg     <= THRESHOLD_RST;
            smooth_reg  <= SMOOTHING_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_ATTACK:    attack_reg  <= cfg_data;
                REG_HOLD:      hold_reg    <= cfg_data;
                REG_RELEASE:   release_reg <= cfg_data;
                REG_THRESHOLD: thr_reg     <= cfg_data[THR_W-1:0];
                REG_SMOOTHING: smooth_reg  <= {1'b0, cfg_data[K_W-2:0]} |
                                              (cfg_data[K_W-1] ? UNITY : '0);
                default:       ;
            endcase
        end
    end

    // Input magnitude and saturated coefficient.
    logic [SAMPLE_BITS-1:0] raw_mag;
    logic [K_W-1:0]         k_sat;
    always_comb
    begin
        raw_mag = sample_in[SAMPLE_BITS-1] ? (~sample_in + 1'b1) : sample_in;
        k_sat   = (smooth_reg > UNITY) ? UNITY : smooth_reg;
    end

    // Shared multiplier operands.
    logic [K_W-1:0]   mul_a;
    logic [ENV_W-1:0] mul_b;
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_MK:
            begin
                mul_a = k_reg;
                mul_b = ENV_W'(mag_reg);
            end
            MUL_ENV:
            begin
                mul_a = UNITY - k_reg;
                mul_b = env_reg;
            end
            MUL_OUT:
            begin
                mul_a = gain_reg;
                mul_b = ENV_W'(mag_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Phase decision and ramp setup.
    logic                  open_now;
    logic [COUNT_BITS-1:0] elapsed, ramp_num;
    logic [CW-1:0]         hold_ext;
    logic [LEN_W-1:0]      len_sel;
    logic                  hold_ok;
    always_comb
    begin
        open_now = env_reg > ENV_W'({thr_reg, 16'd0});
        if (open_now)
        begin
            elapsed = ph_open_reg ? (cnt_reg - ostart_reg) : '0;
        end
        else
        begin
            elapsed = ph_close_reg ? (cnt_reg - cstart_reg) : '0;
        end
        hold_ext = CW'(hold_reg);
        hold_ok  = open_now || (CW'(elapsed) >= hold_ext);
        ramp_num = open_now ? elapsed : COUNT_BITS'(CW'(elapsed) - hold_ext);
        len_sel  = open_now ? attack_reg : release_reg;
        if (len_sel == '0)
        begin
            len_sel = LEN_W'(1);
        end
    end

    // Divider step: one quotient bit a cycle.
    logic [LEN_W:0] rem_sh;
    logic           rem_ge;
    always_comb
    begin
        rem_sh = {rem_reg, 1'b0};
        rem_ge = rem_sh >= {1'b0, len_reg};
    end

    // Gain update.
    logic [GAIN_W-1:0] q_amt, gain_new;
    logic [GAIN_W:0]   up_sum, down_sum;
    always_comb
    begin
        q_amt    = cap_reg ? UNITY : GAIN_W'(quo_reg);
        up_sum   = {1'b0, low_reg} + {1'b0, q_amt};
        down_sum = {1'b0, q_amt} + {1'b0, peak_reg};
        if (open_reg)
        begin
            gain_new = (up_sum > {1'b0, UNITY}) ? UNITY : up_sum[GAIN_W-1:0];
        end
        else if (hold_ok_reg)
        begin
            gain_new = (down_sum >= {1'b0, UNITY}) ? '0 :
                       GAIN_W'({1'b0, UNITY} - down_sum);
        end
        else
        begin
            gain_new = gain_reg;
        end
    end

    // Output value from the last product.
    logic [SAMPLE_BITS-1:0] scaled;
    always_comb
    begin
        scaled = prod_reg[SAMPLE_BITS+15:16];
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= raw_mag;
            neg_reg <= sample_in[SAMPLE_BITS-1];
            k_reg   <= k_sat;
        end
        if (cmd.mul_sel != MUL_NONE)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.env_hold)
        begin
            acc_reg <= prod_reg[ENV_W-1:0];
        end
        if (cmd.decide)
        begin
            open_reg    <= open_now;
            hold_ok_reg <= hold_ok;
            len_reg     <= len_sel;
            cap_reg     <= CW'(ramp_num) >= CW'(len_sel);
            rem_reg     <= LEN_W'(CW'(ramp_num)) &
                           {LEN_W{(CW'(ramp_num) < CW'(len_sel))}};
            quo_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? LEN_W'(rem_sh - {1'b0, len_reg}) : rem_sh[LEN_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
        end
        if (cmd.out_load)
        begin
            out_sample_reg <= neg_reg ? (~scaled + 1'b1) : scaled;
            out_gate_reg   <= open_reg;
        end
    end

    // Gate state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= UNITY;
            env_reg      <= '0;
            low_reg      <= '0;
            peak_reg     <= '0;
            cnt_reg      <= '0;
            ostart_reg   <= '0;
            cstart_reg   <= '0;
            ph_open_reg  <= 1'b0;
            ph_close_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.env_upd)
            begin
                env_reg <= acc_reg + ENV_W'(prod_reg[PROD_W-1:16]);
            end
            if (cmd.decide)
            begin
                if (open_now && !ph_open_reg)
                begin
                    peak_reg     <= gain_reg;
                    ostart_reg   <= cnt_reg;
                    ph_open_reg  <= 1'b1;
                    ph_close_reg <= 1'b0;
                end
                else if (!open_now && !ph_close_reg)
                begin
                    low_reg      <= gain_reg;
                    peak_reg     <= UNITY - peak_reg;
                    cstart_reg   <= cnt_reg;
                    ph_close_reg <= 1'b1;
                    ph_open_reg  <= 1'b0;
                end
            end
            if (cmd.gain_upd)
            begin
                gain_reg <= gain_new;
                if (open_reg)
                begin
                    if (gain_new > peak_reg)
                    begin
                        peak_reg <= gain_new;
                    end
                end
                else if (low_reg > gain_new)
                begin
                    low_reg <= gain_new;
                end
            end
        end
    end

endmodule
`default_nettype wire
